// ===== src/date_period_overlap_days_assert.svh =====
// assertion macros for the date period overlap block
// used by the controller; needs nothing else
`ifndef DATE_PERIOD_OVERLAP_DAYS_ASSERT_SVH
`define DATE_PERIOD_OVERLAP_DAYS_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent in this cycle implies consequent in the next cycle
`define DPOD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dpod assertion failed");

// antecedent implies consequent in the same cycle
`define DPOD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dpod assertion failed");

`else

`define DPOD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define DPOD_ASSERT_NOW(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/dpod_pkg.sv =====
// shared types, constants and calendar tables for the date period overlap block
// no dependencies
package dpod_pkg;

	localparam int DAY_W = 5;
	localparam int MON_W = 4;
	localparam int YR_W  = 14;
	localparam int CNT_W = 22;

	localparam logic [CNT_W-1:0] OUT_MAX = 22'd4194303;

	// floor(n / 25) = (n * DIV25_MUL) >> DIV25_SH for n below 43690
	localparam int DIV25_MUL_W = 15;
	localparam logic [DIV25_MUL_W-1:0] DIV25_MUL = 15'd20972;
	localparam int DIV25_SH = 19;

	localparam logic [MON_W-1:0] MON_JAN = 4'd1;
	localparam logic [MON_W-1:0] MON_FEB = 4'd2;
	localparam logic [MON_W-1:0] MON_DEC = 4'd12;

	typedef struct packed {
		logic [DAY_W-1:0] day;
		logic [MON_W-1:0] mon;
		logic [YR_W-1:0]  yr;
	} dpod_date_t;

	typedef struct packed {
		logic       load;
		logic [1:0] idx;
		logic       store;
		logic       finish;
	} dpod_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEL,
		ST_MUL,
		ST_SER,
		ST_CMP
	} dpod_state_t;

	// days in a common-year month, month already clamped to 1..12
	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] mo);
		logic [DAY_W-1:0] r;
		case (mo)
			4'd2: r = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
			default: r = 5'd31;
		endcase
		return r;
	endfunction

	// days before the first of the month in a common year
	function automatic logic [8:0] month_start(input logic [MON_W-1:0] mo);
		logic [8:0] r;
		case (mo)
			4'd2:  r = 9'd31;
			4'd3:  r = 9'd59;
			4'd4:  r = 9'd90;
			4'd5:  r = 9'd120;
			4'd6:  r = 9'd151;
			4'd7:  r = 9'd181;
			4'd8:  r = 9'd212;
			4'd9:  r = 9'd243;
			4'd10: r = 9'd273;
			4'd11: r = 9'd304;
			4'd12: r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== src/dpod_req_if.sv =====
// request channel: two date periods with valid/ready
// depends on dpod_pkg for field widths
interface dpod_req_if;
	logic                       valid;
	logic                       ready;
	logic [dpod_pkg::DAY_W-1:0] first_start_day;
	logic [dpod_pkg::MON_W-1:0] first_start_month;
	logic [dpod_pkg::YR_W-1:0]  first_start_year;
	logic [dpod_pkg::DAY_W-1:0] first_end_day;
	logic [dpod_pkg::MON_W-1:0] first_end_month;
	logic [dpod_pkg::YR_W-1:0]  first_end_year;
	logic [dpod_pkg::DAY_W-1:0] second_start_day;
	logic [dpod_pkg::MON_W-1:0] second_start_month;
	logic [dpod_pkg::YR_W-1:0]  second_start_year;
	logic [dpod_pkg::DAY_W-1:0] second_end_day;
	logic [dpod_pkg::MON_W-1:0] second_end_month;
	logic [dpod_pkg::YR_W-1:0]  second_end_year;

	modport source (
		output valid, first_start_day, first_start_month, first_start_year,
		output first_end_day, first_end_month, first_end_year,
		output second_start_day, second_start_month, second_start_year,
		output second_end_day, second_end_month, second_end_year,
		input  ready
	);

	modport sink (
		input  valid, first_start_day, first_start_month, first_start_year,
		input  first_end_day, first_end_month, first_end_year,
		input  second_start_day, second_start_month, second_start_year,
		input  second_end_day, second_end_month, second_end_year,
		output ready
	);
endinterface

// ===== src/dpod_rsp_if.sv =====
// response channel: overlap day count with valid/ready
// depends on dpod_pkg for the count width
interface dpod_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [dpod_pkg::CNT_W-1:0] overlap_days;

	modport source (output valid, overlap_days, input ready);
	modport sink (input valid, overlap_days, output ready);
endinterface

// ===== src/dpod_ctrl.sv =====
// controller: sequences the four date conversions and the final compare
// depends on dpod_pkg and the assertion macro header
`include "date_period_overlap_days_assert.svh"

module dpod_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output dpod_pkg::dpod_cmd_t cmd
);

	dpod_pkg::dpod_state_t state_q, state_d;
	logic [1:0] idx_q, idx_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dpod_pkg::ST_IDLE;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		cmd.load   = 1'b0;
		cmd.idx    = idx_q;
		cmd.store  = 1'b0;
		cmd.finish = 1'b0;
		in_ready   = 1'b0;
		case (state_q)
			dpod_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					idx_d    = 2'd0;
					state_d  = dpod_pkg::ST_SEL;
				end
			end
			dpod_pkg::ST_SEL: state_d = dpod_pkg::ST_MUL;
			dpod_pkg::ST_MUL: state_d = dpod_pkg::ST_SER;
			dpod_pkg::ST_SER: begin
				cmd.store = 1'b1;
				if (idx_q == 2'd3) begin
					state_d = dpod_pkg::ST_CMP;
				end else begin
					idx_d   = idx_q + 2'd1;
					state_d = dpod_pkg::ST_SEL;
				end
			end
			dpod_pkg::ST_CMP: begin
				// wait until the output register is free or being drained
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = dpod_pkg::ST_IDLE;
				end
			end
			default: state_d = dpod_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	`DPOD_ASSERT_NEXT(a_accept_starts, clk, arst_n, in_valid && in_ready, state_q == dpod_pkg::ST_SEL && idx_q == 2'd0)
	`DPOD_ASSERT_NEXT(a_last_date_cmp, clk, arst_n, state_q == dpod_pkg::ST_SER && idx_q == 2'd3, state_q == dpod_pkg::ST_CMP)
	`DPOD_ASSERT_NEXT(a_finish_valid, clk, arst_n, cmd.finish, out_valid_q && state_q == dpod_pkg::ST_IDLE)
	`DPOD_ASSERT_NOW(a_rise_from_cmp, clk, arst_n, $rose(out_valid_q), $past(state_q) == dpod_pkg::ST_CMP)

endmodule

// ===== src/dpod_datapath.sv =====
// datapath: date clamp, serial day number conversion and overlap count
// depends on dpod_pkg; driven by commands from dpod_ctrl
module dpod_datapath #(
	parameter int MAX_YEAR = 9999
) (
	input  logic                             clk,
	input  dpod_pkg::dpod_cmd_t              cmd,
	input  dpod_pkg::dpod_date_t [3:0]       dates,
	output logic [dpod_pkg::CNT_W-1:0]       overlap_days
);

	localparam int YR_W   = dpod_pkg::YR_W;
	localparam int YR_MAX = (1 << YR_W) - 1;
	localparam int YR_CAP = (MAX_YEAR < YR_MAX) ? MAX_YEAR : YR_MAX;
	localparam int SER_W  = $clog2(YR_CAP * 366 + 1);
	localparam int DIF_W  = SER_W + 1;
	localparam int CMP_W  = (DIF_W > dpod_pkg::CNT_W) ? DIF_W : dpod_pkg::CNT_W;
	localparam int M_W    = YR_W - 2;
	localparam int P_W    = M_W + dpod_pkg::DIV25_MUL_W;
	localparam int Q_W    = P_W - dpod_pkg::DIV25_SH;

	localparam logic [YR_W-1:0] YR_CAP_V = YR_W'(YR_CAP);

	dpod_pkg::dpod_date_t [3:0] date_q;
	logic [SER_W-1:0]           ser_q [4];
	logic [dpod_pkg::CNT_W-1:0] out_q;

	// stage 1: clamped month and year, raw day
	logic [dpod_pkg::DAY_W-1:0] day_s1;
	logic [dpod_pkg::MON_W-1:0] mon_s1;
	logic [YR_W-1:0]            yr_s1;
	// stage 2: year / 100 via reciprocal
	logic [dpod_pkg::DAY_W-1:0] day_s2;
	logic [dpod_pkg::MON_W-1:0] mon_s2;
	logic [YR_W-1:0]            yr_s2;
	logic [Q_W-1:0]             q_s2;

	logic [YR_W-1:0]            yr_c;
	logic [dpod_pkg::MON_W-1:0] mon_c;
	logic [P_W-1:0]             prod;
	logic [SER_W-1:0]           ser;
	logic [dpod_pkg::CNT_W-1:0] cnt;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			date_q <= dates;
		end
		if (cmd.store) begin
			ser_q[cmd.idx] <= ser;
		end
		if (cmd.finish) begin
			out_q <= cnt;
		end
	end

	always_comb begin
		dpod_pkg::dpod_date_t d;
		d = date_q[cmd.idx];
		if (d.yr == '0) begin
			yr_c = YR_W'(1);
		end else if (d.yr > YR_CAP_V) begin
			yr_c = YR_CAP_V;
		end else begin
			yr_c = d.yr;
		end
		if (d.mon < dpod_pkg::MON_JAN) begin
			mon_c = dpod_pkg::MON_JAN;
		end else if (d.mon > dpod_pkg::MON_DEC) begin
			mon_c = dpod_pkg::MON_DEC;
		end else begin
			mon_c = d.mon;
		end
	end

	always_ff @(posedge clk) begin
		day_s1 <= date_q[cmd.idx].day;
		mon_s1 <= mon_c;
		yr_s1  <= yr_c;
	end

	assign prod = P_W'(yr_s1[YR_W-1:2]) * P_W'(dpod_pkg::DIV25_MUL);

	always_ff @(posedge clk) begin
		day_s2 <= day_s1;
		mon_s2 <= mon_s1;
		yr_s2  <= yr_s1;
		q_s2   <= prod[P_W-1:dpod_pkg::DIV25_SH];
	end

	// serial day number from year quotients and month tables
	always_comb begin
		logic [M_W-1:0]             m;
		logic [M_W-1:0]             q25;
		logic                       div4, div100, div400, leap;
		logic [M_W-1:0]             py4;
		logic [Q_W-1:0]             py100;
		logic [Q_W-3:0]             py400;
		logic [YR_W-1:0]            py;
		logic [dpod_pkg::DAY_W-1:0] lim, dy;
		logic                       adj;
		m      = yr_s2[YR_W-1:2];
		q25    = M_W'(q_s2) * M_W'(25);
		div4   = (yr_s2[1:0] == 2'b00);
		div100 = div4 && (m == q25);
		div400 = div100 && (q_s2[1:0] == 2'b00);
		leap   = (div4 && !div100) || div400;
		// quotients of year - 1 from those of year
		py4    = m - M_W'(div4);
		py100  = q_s2 - Q_W'(div100);
		py400  = q_s2[Q_W-1:2] - (Q_W-2)'(div400);
		py     = yr_s2 - YR_W'(1);
		if (mon_s2 == dpod_pkg::MON_FEB && leap) begin
			lim = 5'd29;
		end else begin
			lim = dpod_pkg::month_len(mon_s2);
		end
		if (day_s2 == '0) begin
			dy = 5'd1;
		end else if (day_s2 > lim) begin
			dy = lim;
		end else begin
			dy = day_s2;
		end
		adj = (mon_s2 > dpod_pkg::MON_FEB) && leap;
		ser = SER_W'(py) * SER_W'(365) + SER_W'(py4) - SER_W'(py100) + SER_W'(py400)
			+ SER_W'(dpod_pkg::month_start(mon_s2)) + SER_W'(adj) + SER_W'(dy) - SER_W'(1);
	end

	// common interval of the two periods, saturated to the count width
	always_comb begin
		logic [SER_W-1:0] lo, hi;
		logic [CMP_W-1:0] dif;
		lo  = (ser_q[0] > ser_q[2]) ? ser_q[0] : ser_q[2];
		hi  = (ser_q[1] < ser_q[3]) ? ser_q[1] : ser_q[3];
		dif = CMP_W'(DIF_W'(hi) - DIF_W'(lo) + DIF_W'(1));
		if (hi < lo) begin
			cnt = '0;
		end else if (dif > CMP_W'(dpod_pkg::OUT_MAX)) begin
			cnt = dpod_pkg::OUT_MAX;
		end else begin
			cnt = dif[dpod_pkg::CNT_W-1:0];
		end
	end

	assign overlap_days = out_q;

endmodule

// ===== src/date_period_overlap_days.sv =====
// date period overlap: rsp.valid rises once the four date conversions and the compare are done
// one request is taken at a time, only while idle; a shared date converter
// (clamp, reciprocal multiply for year / 100, serial sum) runs once per date, four times
// the next request is taken while a finished result still waits in the output register
// asynchronous active-low reset returns the controller to idle with no result pending
module date_period_overlap_days #(
	parameter int MAX_YEAR = 9999
) (
	input logic        clk,
	input logic        arst_n,
	dpod_req_if.sink   req,
	dpod_rsp_if.source rsp
);

	dpod_pkg::dpod_cmd_t        cmd;
	dpod_pkg::dpod_date_t [3:0] dates;

	assign dates[0] = '{day: req.first_start_day, mon: req.first_start_month,
		yr: req.first_start_year};
	assign dates[1] = '{day: req.first_end_day, mon: req.first_end_month,
		yr: req.first_end_year};
	assign dates[2] = '{day: req.second_start_day, mon: req.second_start_month,
		yr: req.second_start_year};
	assign dates[3] = '{day: req.second_end_day, mon: req.second_end_month,
		yr: req.second_end_year};

	dpod_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	dpod_datapath #(
		.MAX_YEAR (MAX_YEAR)
	) u_datapath (
		.clk          (clk),
		.cmd          (cmd),
		.dates        (dates),
		.overlap_days (rsp.overlap_days)
	);

endmodule
